>>> hdl/lz5sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz5sd_pkg
// Shared types and constants for the LZ5 stream decompressor.
// ----------------------------------------------------------------------------
package lz5sd_pkg;

  localparam int WINDOW_DEPTH_DEF = 1024;
  localparam int BEAT_BYTES       = 8;
  localparam int LEN_W            = 9;   // longest job is 263 bytes
  localparam int DIST_W           = 11;  // longest distance is 1024

  localparam logic [7:0] RUN_LEN_MASK  = 8'hE0;
  localparam logic [7:0] RUN_VAL_MASK  = 8'h1F;
  localparam logic [7:0] OFS_HI_MASK   = 8'hC0;
  localparam logic [7:0] COPY_LEN_MASK = 8'h3F;
  localparam int         RUN_LONG_ADD  = 8;
  localparam int         COPY_LONG_ADD = 3;
  localparam int         RECYCLE_SLICES = 4;

  // kind of output job started by one input byte
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_RUN,
    JOB_COPY
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // take input byte, parse it
    logic gen;     // produce one output byte
    logic take;    // output beat handed off
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    job_t parse_kind;  // job the current input byte would start
    job_t job_kind;    // job in progress
    logic final_byte;  // one byte left in the job
    logic beat_full;   // beat buffer holds seven bytes
    logic job_done;    // job finished
  } status_t;

endpackage

>>> hdl/lz5sd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz5sd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz5sd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lz5sd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz5sd_ctrl
// Sequencer: byte intake, run/copy byte generation and beat hand-off.
// ----------------------------------------------------------------------------
module lz5sd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lz5sd_pkg::status_t st,
  output lz5sd_pkg::cmd_t    cmd
);

  lz5sd_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lz5sd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      lz5sd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          unique case (st.parse_kind)
            lz5sd_pkg::JOB_RUN:  state_next = lz5sd_pkg::ST_RUN;
            lz5sd_pkg::JOB_COPY: state_next = lz5sd_pkg::ST_COPY_RD;
            default:             state_next = lz5sd_pkg::ST_IDLE;
          endcase
        end
      end
      lz5sd_pkg::ST_RUN: begin
        cmd.gen = 1'b1;
        if (st.final_byte || st.beat_full) begin
          state_next = lz5sd_pkg::ST_EMIT;
        end
      end
      lz5sd_pkg::ST_COPY_RD: begin
        // history read in flight
        state_next = lz5sd_pkg::ST_COPY_WR;
      end
      lz5sd_pkg::ST_COPY_WR: begin
        cmd.gen = 1'b1;
        if (st.final_byte || st.beat_full) begin
          state_next = lz5sd_pkg::ST_EMIT;
        end else begin
          state_next = lz5sd_pkg::ST_COPY_RD;
        end
      end
      lz5sd_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.take = 1'b1;
          if (st.job_done) begin
            state_next = lz5sd_pkg::ST_IDLE;
          end else if (st.job_kind == lz5sd_pkg::JOB_COPY) begin
            state_next = lz5sd_pkg::ST_COPY_RD;
          end else begin
            state_next = lz5sd_pkg::ST_RUN;
          end
        end
      end
      default: state_next = lz5sd_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hdl/lz5sd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz5sd_datapath
// Packet parser, history window, job counters and output beat buffer.
// ----------------------------------------------------------------------------
module lz5sd_datapath #(
  parameter int WINDOW_DEPTH = lz5sd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lz5sd_pkg::cmd_t    cmd,
  output lz5sd_pkg::status_t st,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic [7:0]         out_byte_0,
  output logic [7:0]         out_byte_1,
  output logic [7:0]         out_byte_2,
  output logic [7:0]         out_byte_3,
  output logic [7:0]         out_byte_4,
  output logic [7:0]         out_byte_5,
  output logic [7:0]         out_byte_6,
  output logic [7:0]         out_byte_7,
  output logic [3:0]         out_count,
  output logic               run_last
);

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int AW1 = AW + 1;
  localparam int LW  = lz5sd_pkg::LEN_W;
  localparam int DW  = lz5sd_pkg::DIST_W;

  // parser state
  logic [7:0] ctrl_bits, first_byte, second_byte, roff;
  logic [3:0] ctrl_idx;
  logic [1:0] phase, rcnt;
  // job state
  logic [AW-1:0]     wp, rd;
  lz5sd_pkg::job_t   job_kind;
  logic [4:0]        job_val;
  logic [LW-1:0]     remaining;
  logic              clear_pend, job_done;
  // beat buffer
  logic [7:0] beat [lz5sd_pkg::BEAT_BYTES];
  logic [3:0] fill;

  // parse results
  logic [7:0]      ctrl_bits_next, first_next, second_next, roff_next, roff_or;
  logic [3:0]      ctrl_idx_next;
  logic [1:0]      phase_next, rcnt_next;
  lz5sd_pkg::job_t pk;
  logic [LW-1:0]   plen;
  logic [4:0]      pval;
  logic [DW-1:0]   pdist;
  logic            pdone;
  logic [AW1-1:0]  wp_x, dist_x, rd_calc;
  logic [AW-1:0]   rd_start, wp_inc, rd_inc;
  logic [7:0]      gbyte, ram_rdata;

  // decode one compressed byte against the parser state
  always_comb begin
    ctrl_bits_next = ctrl_bits;
    ctrl_idx_next  = ctrl_idx;
    phase_next     = phase;
    first_next     = first_byte;
    second_next    = second_byte;
    roff_next      = roff;
    rcnt_next      = rcnt;
    pk             = lz5sd_pkg::JOB_NONE;
    plen           = '0;
    pval           = '0;
    pdist          = '0;
    pdone          = 1'b0;
    roff_or        = roff | ((data_byte & lz5sd_pkg::OFS_HI_MASK) >> {rcnt, 1'b0});
    if (ctrl_idx[3]) begin
      ctrl_bits_next = data_byte;
      ctrl_idx_next  = '0;
      phase_next     = '0;
    end else if (!ctrl_bits[ctrl_idx[2:0]]) begin
      // RLE packet
      if (phase == 2'd0) begin
        if ((data_byte & lz5sd_pkg::RUN_LEN_MASK) != 8'd0) begin
          pk    = lz5sd_pkg::JOB_RUN;
          pval  = data_byte[4:0];
          plen  = LW'(data_byte[7:5]);
          pdone = 1'b1;
        end else begin
          first_next = data_byte;
          phase_next = 2'd1;
        end
      end else begin
        pk    = lz5sd_pkg::JOB_RUN;
        pval  = first_byte[4:0];
        plen  = LW'(data_byte) + LW'(lz5sd_pkg::RUN_LONG_ADD);
        pdone = 1'b1;
      end
    end else begin
      // LZ packet
      if (phase == 2'd0) begin
        first_next = data_byte;
        phase_next = 2'd1;
        if ((data_byte & lz5sd_pkg::COPY_LEN_MASK) != 8'd0) begin
          if (rcnt == 2'(lz5sd_pkg::RECYCLE_SLICES - 1)) begin
            // fourth short copy: recycled offset gives the distance
            pk        = lz5sd_pkg::JOB_COPY;
            pdist     = DW'(roff_or) + DW'(1);
            plen      = LW'(data_byte[5:0]) + LW'(1);
            roff_next = '0;
            rcnt_next = '0;
            pdone     = 1'b1;
          end else begin
            roff_next = roff_or;
            rcnt_next = rcnt + 2'd1;
          end
        end
      end else if (phase == 2'd1) begin
        if ((first_byte & lz5sd_pkg::COPY_LEN_MASK) != 8'd0) begin
          pk    = lz5sd_pkg::JOB_COPY;
          pdist = DW'(data_byte) + DW'(1);
          plen  = LW'(first_byte[5:0]) + LW'(1);
          pdone = 1'b1;
        end else begin
          second_next = data_byte;
          phase_next  = 2'd2;
        end
      end else begin
        pk    = lz5sd_pkg::JOB_COPY;
        pdist = DW'({first_byte[7:6], second_byte}) + DW'(1);
        plen  = LW'(data_byte) + LW'(lz5sd_pkg::COPY_LONG_ADD);
        pdone = 1'b1;
      end
    end
    if (pdone) begin
      ctrl_idx_next = ctrl_idx + 4'd1;
      phase_next    = '0;
    end
  end

  // copy source: write pointer minus distance, modulo window depth
  assign wp_x     = AW1'(wp);
  assign dist_x   = AW1'(pdist);
  assign rd_calc  = (wp_x >= dist_x) ? (wp_x - dist_x)
                                     : (wp_x + AW1'(WINDOW_DEPTH) - dist_x);
  assign rd_start = rd_calc[AW-1:0];
  assign wp_inc   = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + AW'(1);
  assign rd_inc   = (rd == AW'(WINDOW_DEPTH - 1)) ? '0 : rd + AW'(1);

  assign gbyte = (job_kind == lz5sd_pkg::JOB_COPY) ? ram_rdata : {3'b000, job_val};

  // history window
  lz5sd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.gen),
    .waddr (wp),
    .wdata (gbyte),
    .raddr (rd),
    .rdata (ram_rdata)
  );

  // parser, job and beat registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_bits   <= '0;
      ctrl_idx    <= 4'd8;
      phase       <= '0;
      first_byte  <= '0;
      second_byte <= '0;
      roff        <= '0;
      rcnt        <= '0;
      wp          <= '0;
      job_kind    <= lz5sd_pkg::JOB_NONE;
      clear_pend  <= 1'b0;
      job_done    <= 1'b0;
      fill        <= '0;
      for (int i = 0; i < lz5sd_pkg::BEAT_BYTES; i++) begin
        beat[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        if (last_byte) begin
          ctrl_bits   <= '0;
          ctrl_idx    <= 4'd8;
          phase       <= '0;
          first_byte  <= '0;
          second_byte <= '0;
          roff        <= '0;
          rcnt        <= '0;
          if (pk == lz5sd_pkg::JOB_NONE) begin
            wp <= '0;
          end
        end else begin
          ctrl_bits   <= ctrl_bits_next;
          ctrl_idx    <= ctrl_idx_next;
          phase       <= phase_next;
          first_byte  <= first_next;
          second_byte <= second_next;
          roff        <= roff_next;
          rcnt        <= rcnt_next;
        end
        job_kind   <= pk;
        job_val    <= pval;
        remaining  <= plen;
        rd         <= rd_start;
        clear_pend <= last_byte;
        job_done   <= 1'b0;
      end
      // one output byte into history and beat buffer
      if (cmd.gen) begin
        beat[fill[2:0]] <= gbyte;
        fill            <= fill + 4'd1;
        remaining       <= remaining - LW'(1);
        rd              <= rd_inc;
        if (remaining == LW'(1)) begin
          job_done <= 1'b1;
          wp       <= clear_pend ? '0 : wp_inc;
        end else begin
          wp <= wp_inc;
        end
      end
      // beat handed off: empty the buffer
      if (cmd.take) begin
        fill <= '0;
        for (int i = 0; i < lz5sd_pkg::BEAT_BYTES; i++) begin
          beat[i] <= '0;
        end
      end
    end
  end

  // status
  assign st.parse_kind = pk;
  assign st.job_kind   = job_kind;
  assign st.final_byte = (remaining == LW'(1));
  assign st.beat_full  = (fill == 4'(lz5sd_pkg::BEAT_BYTES - 1));
  assign st.job_done   = job_done;

  assign out_byte_0 = beat[0];
  assign out_byte_1 = beat[1];
  assign out_byte_2 = beat[2];
  assign out_byte_3 = beat[3];
  assign out_byte_4 = beat[4];
  assign out_byte_5 = beat[5];
  assign out_byte_6 = beat[6];
  assign out_byte_7 = beat[7];
  assign out_count  = fill;
  assign run_last   = job_done;

endmodule

>>> hdl/lz5_stream_decompressor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz5_stream_decompressor_top
// LZ5 decompressor: compressed bytes in, beats of up to 8 bytes out.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// input   | in        | in_valid / in_ready | data_byte, last_byte
// output  | out       | out_valid/out_ready | out_byte_0..7, out_count, run_last
//
// A control byte or a partial packet starts no job. A run makes 1 byte per
// cycle; a copy alternates a history read state and a write state per byte,
// set by the history RAM's registered read and the write-before-read needed
// for overlapping copies. Each beat waits in the emit state while out_ready
// is low; generation stops while a beat waits. Input is taken only after an
// item's last beat. Reset is synchronous; the history window is not cleared.
// ----------------------------------------------------------------------------
module lz5_stream_decompressor_top #(
  parameter int WINDOW_DEPTH = lz5sd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_0,
  output logic [7:0] out_byte_1,
  output logic [7:0] out_byte_2,
  output logic [7:0] out_byte_3,
  output logic [7:0] out_byte_4,
  output logic [7:0] out_byte_5,
  output logic [7:0] out_byte_6,
  output logic [7:0] out_byte_7,
  output logic [3:0] out_count,
  output logic       run_last
);

  lz5sd_pkg::cmd_t    cmd;
  lz5sd_pkg::status_t st;

  lz5sd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  lz5sd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_byte_0 (out_byte_0),
    .out_byte_1 (out_byte_1),
    .out_byte_2 (out_byte_2),
    .out_byte_3 (out_byte_3),
    .out_byte_4 (out_byte_4),
    .out_byte_5 (out_byte_5),
    .out_byte_6 (out_byte_6),
    .out_byte_7 (out_byte_7),
    .out_count  (out_count),
    .run_last   (run_last)
  );

endmodule

>>> tb/sv/lz5_stream_decompressor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz5_stream_decompressor_top_tb
// Self-checking bench for the LZ5 stream decompressor. Compressed streams are
// built packet by packet from a software copy of the parser and history, so
// copies only reach history that holds data. Every beat is checked against
// the bytes that this copy expands. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module lz5_stream_decompressor_top_tb;

  localparam int DEPTH    = 1024;
  localparam int LIMIT    = 1000000;
  localparam int IDLE_PCT = 23;

  typedef struct {
    logic [7:0] bytes [lz5sd_pkg::BEAT_BYTES];
    logic [3:0] cnt;
    logic       last;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_0, out_byte_1, out_byte_2, out_byte_3;
  logic [7:0] out_byte_4, out_byte_5, out_byte_6, out_byte_7;
  logic [3:0] out_count;
  logic       run_last;

  // software copy of the decompressor state
  logic [7:0] hist [DEPTH];
  bit         hist_set [DEPTH];
  int         wp, ctl_bits, ctl_idx, phase, pkt_b0, pkt_b1, rec_ofs, rec_cnt;

  beat_t      beat_q [$];
  logic       in_fire = 1'b0;
  bit         quiet = 1'b0;
  int         errors = 0;
  int         cycles = 0;
  int         bytes_sent = 0;
  int         beats_seen = 0;
  int         streams = 0;

  always #1 clk = ~clk;

  lz5_stream_decompressor_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte_0(out_byte_0), .out_byte_1(out_byte_1),
    .out_byte_2(out_byte_2), .out_byte_3(out_byte_3),
    .out_byte_4(out_byte_4), .out_byte_5(out_byte_5),
    .out_byte_6(out_byte_6), .out_byte_7(out_byte_7),
    .out_count(out_count), .run_last(run_last)
  );

  // input beat taken at this edge
  always @(posedge clk) in_fire <= in_valid && in_ready && !rst;

  // receiver stalls
  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, beat_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output checker
  always @(posedge clk) begin
    beat_t      e;
    logic [7:0] got [lz5sd_pkg::BEAT_BYTES];
    bit         bad;
    if (!rst && out_valid && out_ready) begin
      got = '{out_byte_0, out_byte_1, out_byte_2, out_byte_3,
              out_byte_4, out_byte_5, out_byte_6, out_byte_7};
      beats_seen++;
      if (beat_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: count %0d", out_count);
      end else begin
        e = beat_q.pop_front();
        bad = (out_count !== e.cnt) || (run_last !== e.last);
        for (int k = 0; k < lz5sd_pkg::BEAT_BYTES; k++) if (got[k] !== e.bytes[k]) bad = 1;
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("beat %0d mismatch: count %0d/%0d last %0d/%0d (exp/got)",
                     beats_seen, e.cnt, out_count, e.last, run_last);
            for (int k = 0; k < lz5sd_pkg::BEAT_BYTES; k++)
              $display("  byte %0d: exp %02h got %02h", k, e.bytes[k], got[k]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // expansion of one compressed byte into expected beats
  // ---------------------------------------------------------------------------
  task automatic expand_byte(input logic [7:0] b, input logic fin);
    logic [7:0] outb [$];
    logic [7:0] v;
    beat_t      bt;
    bit         done;
    int         len, dst, ofs;
    done = 0;
    if (ctl_idx >= 8) begin
      ctl_bits = b; ctl_idx = 0; phase = 0;
    end else if (!ctl_bits[ctl_idx]) begin
      if (phase == 0 && (b & lz5sd_pkg::RUN_LEN_MASK) != 0) begin
        v = b & lz5sd_pkg::RUN_VAL_MASK;
        for (int i = 0; i < b[7:5]; i++) begin
          outb.push_back(v);
          hist[wp] = v; hist_set[wp] = 1; wp = (wp + 1) % DEPTH;
        end
        done = 1;
      end else if (phase == 0) begin
        pkt_b0 = b; phase = 1;
      end else begin
        v = 8'(pkt_b0) & lz5sd_pkg::RUN_VAL_MASK;
        for (int i = 0; i < b + lz5sd_pkg::RUN_LONG_ADD; i++) begin
          outb.push_back(v);
          hist[wp] = v; hist_set[wp] = 1; wp = (wp + 1) % DEPTH;
        end
        done = 1;
      end
    end else begin
      len = 0;
      if (phase == 0 && (b & lz5sd_pkg::COPY_LEN_MASK) != 0) begin
        rec_ofs |= ((b & lz5sd_pkg::OFS_HI_MASK) >> (rec_cnt * 2)) & 8'hFF;
        rec_cnt++;
        if (rec_cnt >= lz5sd_pkg::RECYCLE_SLICES) begin
          dst = rec_ofs + 1; len = (b & lz5sd_pkg::COPY_LEN_MASK) + 1;
          rec_ofs = 0; rec_cnt = 0;
        end else begin
          pkt_b0 = b; phase = 1;
        end
      end else if (phase == 0) begin
        pkt_b0 = b; phase = 1;
      end else if (phase == 1 && (pkt_b0 & lz5sd_pkg::COPY_LEN_MASK) != 0) begin
        dst = b + 1; len = (pkt_b0 & lz5sd_pkg::COPY_LEN_MASK) + 1;
      end else if (phase == 1) begin
        pkt_b1 = b; phase = 2;
      end else begin
        ofs = ((pkt_b0 & lz5sd_pkg::OFS_HI_MASK) << 2) | pkt_b1;
        dst = ofs + 1; len = b + lz5sd_pkg::COPY_LONG_ADD;
      end
      // byte-wise copy, overlap repeats bytes
      for (int i = 0; i < len; i++) begin
        outb.push_back(hist[(wp + DEPTH - (dst % DEPTH)) % DEPTH]);
        hist[wp] = outb[$]; hist_set[wp] = 1; wp = (wp + 1) % DEPTH;
      end
      done = (len != 0);
    end
    if (done) begin
      ctl_idx++; phase = 0;
    end
    if (fin) begin
      ctl_bits = 0; ctl_idx = 8; phase = 0; pkt_b0 = 0; pkt_b1 = 0;
      rec_ofs = 0; rec_cnt = 0; wp = 0;
    end
    for (int p = 0; p < outb.size(); p += lz5sd_pkg::BEAT_BYTES) begin
      bt.cnt = (outb.size() - p > lz5sd_pkg::BEAT_BYTES) ? 4'(lz5sd_pkg::BEAT_BYTES)
                                                         : 4'(outb.size() - p);
      for (int j = 0; j < lz5sd_pkg::BEAT_BYTES; j++)
        bt.bytes[j] = (j < bt.cnt) ? outb[p + j] : 8'h00;
      bt.last = (p + lz5sd_pkg::BEAT_BYTES >= outb.size());
      beat_q.push_back(bt);
    end
  endtask

  // sender: one compressed byte, random idle before it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(negedge clk); while (!in_fire);
    expand_byte(b, fin);
    bytes_sent++;
    if (fin) streams++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (beat_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // copy source fully written before this copy can read it
  function automatic bit src_ok(int dst, int len);
    int n;
    n = (len < dst) ? len : dst;
    for (int i = 0; i < n; i++)
      if (!hist_set[(wp - dst + i + 2 * DEPTH) % DEPTH]) return 0;
    return 1;
  endfunction

  function automatic int pick_dist(int hi, int len);
    int d;
    for (int t = 0; t < 8; t++) begin
      d = $urandom_range(1, hi);
      if (src_ok(d, len)) return d;
    end
    for (d = 1; d <= hi; d++) if (src_ok(d, len)) return d;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // one well-formed packet (or control byte), possibly cut or ending a stream
  // ---------------------------------------------------------------------------
  task automatic send_packet();
    logic [7:0] pk [$];
    logic [7:0] b;
    logic [1:0] top;
    int         len, d, cut;
    if (ctl_idx >= 8) begin
      b = $urandom;
      if (!src_ok(1, 1)) b[0] = 1'b0;
      pk.push_back(b);
    end else if (!ctl_bits[ctl_idx]) begin
      if ($urandom_range(99) < 55) begin
        pk.push_back({3'($urandom_range(1, 7)), 5'($urandom)});
      end else begin
        pk.push_back({3'b000, 5'($urandom)});
        pk.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
      end
    end else begin
      len = 0;
      if (rec_cnt == 3 && $urandom_range(99) < 75) begin
        len = $urandom_range(1, 64);
        for (int t = 0; t < 4 && pk.size() == 0; t++) begin
          top = $urandom;
          if (src_ok((rec_ofs | top) + 1, len)) pk.push_back({top, 6'(len - 1)});
        end
      end
      if (pk.size() == 0 && rec_cnt < 3 && $urandom_range(99) < 55) begin
        len = ($urandom_range(7) == 0) ? 64 : $urandom_range(1, 12);
        d = pick_dist(256, len);
        if (d == 0) d = pick_dist(256, 1);
        if (d != 0) begin
          if (!src_ok(d, len)) len = 1;
          pk.push_back({2'($urandom), 6'(len - 1)});
          pk.push_back(8'(d - 1));
        end
      end
      if (pk.size() == 0) begin
        len = ($urandom_range(9) == 0) ? 258 : $urandom_range(3, 20);
        d = pick_dist(DEPTH, len);
        if (d == 0) begin
          len = 3; d = pick_dist(DEPTH, len);
        end
        pk.push_back({2'((d - 1) >> 8), 6'b0});
        pk.push_back(8'(d - 1));
        pk.push_back(8'(len - 3));
      end
    end
    // stream end: cut packet, or final byte on a packet boundary
    cut = ($urandom_range(99) < 4) ? $urandom_range(0, pk.size() - 1) : -1;
    for (int i = 0; i < pk.size(); i++) begin
      if (i == cut) begin
        send_byte(pk[i], 1'b1);
        return;
      end
      send_byte(pk[i], (i == pk.size() - 1) && ($urandom_range(99) < 4));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // runs at both extremes, then enough bytes to fill the whole window
  task automatic test_runs();
    logic [7:0] s [] = '{8'h00, 8'hFF, 8'h20, 8'h00, 8'hFF, 8'h1F, 8'hFF,
                         8'h15, 8'hFF, 8'h0A, 8'hFF, 8'hE1, 8'h41};
    foreach (s[i]) send_byte(s[i], 1'b0);
  endtask

  // recycled short copies, longest and shortest long copies, cut packet
  task automatic test_copies();
    logic [7:0] s [] = '{8'hFF, 8'h7F, 8'h00, 8'h81, 8'hFF, 8'hC1, 8'h10,
                         8'h01, 8'hC0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                         8'h3F, 8'h05};
    foreach (s[i]) send_byte(s[i], 1'b0);
    send_byte(8'h40, 1'b1);
    send_byte(8'h5A, 1'b1);  // stream of a lone control byte
  endtask

  task automatic test_random(int n_bytes);
    int stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      quiet = (bytes_sent > stop - n_bytes / 2) && (bytes_sent < stop - n_bytes / 4);
      send_packet();
    end
    quiet = 0;
  endtask

  // sender holds off until every beat has arrived, then resumes
  task automatic test_hold_off();
    test_random(40);
    drain();
    test_random(40);
  endtask

  initial begin
    wp = 0; ctl_bits = 0; ctl_idx = 8; phase = 0;
    pkt_b0 = 0; pkt_b1 = 0; rec_ofs = 0; rec_cnt = 0;
    foreach (hist_set[i]) hist_set[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);
    test_runs();
    test_copies();
    test_random(90);
    test_hold_off();
    drain();
    $display("sent %0d compressed bytes in %0d streams, checked %0d beats",
             bytes_sent, streams, beats_seen);
    $display("runs, short/recycled/long copies, cut packets; %0d errors", errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
